>>> src/sha1_pkg.sv
// Shared types, constants and round functions for the SHA-1 hash unit.
package sha1_pkg;

    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned DIGEST_WORDS = 5;
    localparam int unsigned LEN_START   = 56;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

    // Padding byte source
    localparam logic [1:0] PAD_MARK = 2'd0;
    localparam logic [1:0] PAD_ZERO = 2'd1;
    localparam logic [1:0] PAD_LEN  = 2'd2;

    typedef struct packed {
        logic       push_msg;
        logic       push_pad;
        logic [1:0] pad_sel;
        logic       load_vars;
        logic       round_en;
        logic [6:0] round_idx;
        logic       add_chain;
        logic       finish;
        logic [2:0] word_sel;
    } sha1_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
    } sha1_status_t;

    function automatic logic [31:0] sha1_f(input logic [6:0] t, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] r;
        if (t < 7'd20)
        begin
            r = (b & c) | (~b & d);
        end
        else if (t < 7'd40)
        begin
            r = b ^ c ^ d;
        end
        else if (t < 7'd60)
        begin
            r = (b & c) | (b & d) | (c & d);
        end
        else
        begin
            r = b ^ c ^ d;
        end
        return r;
    endfunction

    function automatic logic [31:0] sha1_k(input logic [6:0] t);
        logic [31:0] r;
        if (t < 7'd20)
        begin
            r = K0;
        end
        else if (t < 7'd40)
        begin
            r = K1;
        end
        else if (t < 7'd60)
        begin
            r = K2;
        end
        else
        begin
            r = K3;
        end
        return r;
    endfunction

endpackage

>>> src/sha1_hash_unit.sv
// SHA-1 hash unit over a byte stream: five digest words per message.
// Throughput: one byte per cycle while a block fills; the transaction that ends a 64-byte
//   block loads the round registers, then input is held through the 80 rounds and the chaining add.
// After the last transaction: padding bytes up to the block end and a compression, plus a
//   further padding block and compression when the length needs an extra block; then 5 words.
// Reset: rst_n clears control state and loads the initial chaining value; no clearing pass.
module sha1_hash_unit
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha1_cmd_t    cmd;
    sha1_status_t status;

    sha1_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_valid (byte_valid),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .word_index (word_index),
        .last_word  (last_word),
        .status     (status),
        .cmd        (cmd)
    );

    sha1_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .status      (status),
        .digest_word (digest_word)
    );

    // Input is held off whenever the digest is being delivered
    a_no_input_during_output: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while digest words pending");

    // After the final word the unit returns to taking bytes
    a_ready_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_word) |=> (!out_valid && !in_stall))
        else $error("unit did not return to idle after digest");

    // Word index advances by one per output transaction within a digest
    a_index_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_word) |=>
            (out_valid && (word_index == $past(word_index) + 3'd1)))
        else $error("digest word index did not advance");

endmodule

>>> src/sha1_datapath.sv
// SHA-1 datapath: message window, round registers, chaining value and counters.
module sha1_datapath
    import sha1_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  sha1_cmd_t    cmd,
    input  logic [7:0]   data_byte,
    output sha1_status_t status,
    output logic [31:0]  digest_word
);

    logic [511:0] win_reg, win_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  h_reg [DIGEST_WORDS];
    logic [60:0]  count_reg;
    logic [5:0]   fill_reg;

    logic [63:0]  len_bits;
    logic [2:0]   len_idx;
    logic [7:0]   pad_byte;
    logic [31:0]  w0, w2, w8, w13, w_exp, w_t, tmp;

    assign len_bits = {count_reg, 3'b000};
    assign len_idx  = 3'd7 - fill_reg[2:0];

    always_comb
    begin
        unique case (cmd.pad_sel)
            PAD_MARK: pad_byte = PAD_MARK_BYTE;
            PAD_LEN:  pad_byte = len_bits[{len_idx, 3'b000} +: 8];
            default:  pad_byte = 8'h00;
        endcase
    end

    // Schedule taps: oldest word at the top of the window
    assign w0    = win_reg[511:480];
    assign w2    = win_reg[447:416];
    assign w8    = win_reg[255:224];
    assign w13   = win_reg[95:64];
    assign w_exp = {(w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0]),
                    (w13[31] ^ w8[31] ^ w2[31] ^ w0[31])};
    assign w_t   = (cmd.round_idx < 7'd16) ? w0 : w_exp;
    assign tmp   = {a_reg[26:0], a_reg[31:27]} + sha1_f(cmd.round_idx, b_reg, c_reg, d_reg)
                   + e_reg + sha1_k(cmd.round_idx) + w_t;

    always_comb
    begin
        win_next = win_reg;
        if (cmd.push_msg)
        begin
            win_next = {win_reg[503:0], data_byte};
        end
        else if (cmd.push_pad)
        begin
            win_next = {win_reg[503:0], pad_byte};
        end
        else if (cmd.round_en)
        begin
            win_next = {win_reg[479:0], w_t};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (cmd.load_vars)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (cmd.round_en)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg[0]  <= IV0;
            h_reg[1]  <= IV1;
            h_reg[2]  <= IV2;
            h_reg[3]  <= IV3;
            h_reg[4]  <= IV4;
            count_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            if (cmd.push_msg)
            begin
                count_reg <= count_reg + 61'd1;
            end
            if (cmd.push_msg || cmd.push_pad)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.add_chain)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            else if (cmd.finish)
            begin
                h_reg[0]  <= IV0;
                h_reg[1]  <= IV1;
                h_reg[2]  <= IV2;
                h_reg[3]  <= IV3;
                h_reg[4]  <= IV4;
                count_reg <= '0;
            end
        end
    end

    always_comb
    begin
        unique case (cmd.word_sel)
            3'd0:    digest_word = h_reg[0];
            3'd1:    digest_word = h_reg[1];
            3'd2:    digest_word = h_reg[2];
            3'd3:    digest_word = h_reg[3];
            default: digest_word = h_reg[4];
        endcase
    end

    assign status.fill = fill_reg;

endmodule

>>> src/sha1_ctrl.sv
// SHA-1 controller: input handshake, padding sequence, round count and digest output.
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         byte_valid,
    input  logic         last,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [2:0]   word_index,
    output logic         last_word,
    input  sha1_status_t status,
    output sha1_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
    localparam logic [2:0] LAST_WORD  = 3'(DIGEST_WORDS - 1);
    localparam logic [5:0] LEN_POS    = 6'(LEN_START);

    logic [2:0] state_reg, state_next;
    logic [6:0] rc_reg, rc_next;
    logic [2:0] oi_reg, oi_next;
    logic       first_reg, first_next;
    logic       len_ok_reg, len_ok_next;
    logic       final_reg, final_next;
    logic       pend_reg, pend_next;
    logic       pad_mode_reg, pad_mode_next;
    logic       block_end;

    assign block_end = (status.fill == 6'h3f);

    always_comb
    begin
        state_next    = state_reg;
        rc_next       = rc_reg;
        oi_next       = oi_reg;
        first_next    = first_reg;
        len_ok_next   = len_ok_reg;
        final_next    = final_reg;
        pend_next     = pend_reg;
        pad_mode_next = pad_mode_reg;
        cmd           = '0;
        cmd.round_idx = rc_reg;
        cmd.word_sel  = oi_reg;
        cmd.pad_sel   = PAD_ZERO;
        in_stall      = 1'b1;
        out_valid     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (byte_valid)
                    begin
                        cmd.push_msg = 1'b1;
                        if (block_end)
                        begin
                            cmd.load_vars = 1'b1;
                            pend_next     = last;
                            rc_next       = '0;
                            state_next    = ST_ROUND;
                        end
                        else if (last)
                        begin
                            state_next    = ST_PAD;
                            first_next    = 1'b1;
                            len_ok_next   = 1'b0;
                            pad_mode_next = 1'b1;
                        end
                    end
                    else if (last)
                    begin
                        state_next    = ST_PAD;
                        first_next    = 1'b1;
                        len_ok_next   = 1'b0;
                        pad_mode_next = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.push_pad = 1'b1;
                first_next   = 1'b0;
                if (first_reg)
                begin
                    cmd.pad_sel = PAD_MARK;
                    if (status.fill < LEN_POS)
                    begin
                        len_ok_next = 1'b1;
                    end
                end
                else if (len_ok_reg && (status.fill >= LEN_POS))
                begin
                    cmd.pad_sel = PAD_LEN;
                end
                if (block_end)
                begin
                    cmd.load_vars = 1'b1;
                    rc_next       = '0;
                    final_next    = (cmd.pad_sel == PAD_LEN);
                    // if the length did not fit here, it goes into the block after this one
                    len_ok_next   = 1'b1;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                rc_next      = rc_reg + 7'd1;
                if (rc_reg == LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.add_chain = 1'b1;
                if (final_reg)
                begin
                    oi_next    = '0;
                    state_next = ST_OUT;
                end
                else if (pend_reg)
                begin
                    pend_next     = 1'b0;
                    first_next    = 1'b1;
                    len_ok_next   = 1'b0;
                    pad_mode_next = 1'b1;
                    state_next    = ST_PAD;
                end
                else if (pad_mode_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (oi_reg == LAST_WORD)
                    begin
                        cmd.finish    = 1'b1;
                        final_next    = 1'b0;
                        pad_mode_next = 1'b0;
                        len_ok_next   = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        oi_next = oi_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rc_reg       <= '0;
            oi_reg       <= '0;
            first_reg    <= 1'b0;
            len_ok_reg   <= 1'b0;
            final_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            pad_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rc_reg       <= rc_next;
            oi_reg       <= oi_next;
            first_reg    <= first_next;
            len_ok_reg   <= len_ok_next;
            final_reg    <= final_next;
            pend_reg     <= pend_next;
            pad_mode_reg <= pad_mode_next;
        end
    end

    assign word_index = oi_reg;
    assign last_word  = (oi_reg == LAST_WORD);

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the SHA-1 hash unit: byte stream in, digest words out.
module testbench
    import sha1_pkg::*;
();

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        closing;
    } digest_exp_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    // Predicted hash state
    logic [31:0] chain_words [5];
    logic [7:0]  block_bytes [64];
    logic [60:0] byte_count;
    digest_exp_t digest_queue [$];
    digest_exp_t head_word;

    int err_count     = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;

    sha1_hash_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    always #5 clk = ~clk;

    function automatic void clear_hash_state();
        int i;
        chain_words[0] = IV0;
        chain_words[1] = IV1;
        chain_words[2] = IV2;
        chain_words[3] = IV3;
        chain_words[4] = IV4;
        for (i = 0; i < 64; i++)
        begin
            block_bytes[i] = 8'h00;
        end
        byte_count = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        int t;
        for (t = 0; t < 16; t++)
        begin
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                    block_bytes[4*t+3]};
        end
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        e = chain_words[4];
        for (t = 0; t < 80; t++)
        begin
            // Expand the schedule in place over a 16-word window
            if (t >= 16)
            begin
                tmp = w[(t-3) & 15] ^ w[(t-8) & 15] ^ w[(t-14) & 15] ^ w[t & 15];
                w[t & 15] = {tmp[30:0], tmp[31]};
            end
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + w[t & 15];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
        chain_words[4] += e;
    endfunction

    function automatic void predict_item(input logic [7:0] b, input logic v, input logic l);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        digest_exp_t dw;
        int i;
        if (v)
        begin
            block_bytes[byte_count[5:0]] = b;
            byte_count = byte_count + 61'd1;
            if (byte_count[5:0] == 6'd0)
            begin
                compress_block();
            end
        end
        if (l)
        begin
            pos = byte_count[5:0];
            block_bytes[pos] = PAD_MARK_BYTE;
            for (i = pos + 1; i < 64; i++)
            begin
                block_bytes[i] = 8'h00;
            end
            // No room for the length field: spill into one more block
            if (pos >= LEN_START)
            begin
                compress_block();
                for (i = 0; i < 64; i++)
                begin
                    block_bytes[i] = 8'h00;
                end
            end
            bit_len = {byte_count, 3'b000};
            for (i = 0; i < 8; i++)
            begin
                block_bytes[56 + i] = bit_len[63 - 8*i -: 8];
            end
            compress_block();
            for (i = 0; i < 5; i++)
            begin
                dw.word    = chain_words[i];
                dw.index   = i[2:0];
                dw.closing = (i == 4);
                digest_queue.push_back(dw);
            end
            clear_hash_state();
        end
    endfunction

    task automatic send_item(input logic [7:0] b, input logic v, input logic l);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        byte_valid <= v;
        last       <= l;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_item(b, v, l);
    endtask

    // Random bytes, with ignored items sprinkled in; end on the last byte or by a marker
    task automatic send_message(input int len, output int sent);
        logic marker_end;
        int n;
        marker_end = (len == 0) || ($urandom_range(0, 1) == 1);
        sent = 0;
        for (n = 0; n < len; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_item(8'($urandom_range(0, 255)), 1'b1, !marker_end && (n == len - 1));
            sent++;
        end
        if (marker_end)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            sent++;
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        // Empty message
        send_item(8'h00, 1'b0, 1'b1);
        // Ignored item, then a single zero byte carrying last
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        // All-ones byte closed by an empty end marker
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // Ignored item in mid-message
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'haa, 1'b0, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
    endtask

    // Messages that land just below and at the length field, and at the block end
    task automatic test_block_boundaries();
        int sent;
        send_idle_pct = 20;
        stall_pct     = 20;
        send_message(55, sent);
        send_message(56, sent);
        send_message(64, sent);
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int n_items);
        int sent;
        int total;
        int len;
        send_idle_pct = idle;
        stall_pct     = stall;
        total = 0;
        while (total < n_items)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                len = $urandom_range(60, 70);
            end
            else
            begin
                len = $urandom_range(0, 12);
            end
            send_message(len, sent);
            total += sent;
        end
    endtask

    task automatic test_output_hold();
        int sent;
        int m;
        send_idle_pct = 0;
        stall_pct     = 0;
        in_valid <= 1'b0;
        @(negedge clk);
        hold_left = 400;
        @(posedge clk);
        // Keep offering while the receiver holds off, so the input backs up
        for (m = 0; m < 5; m++)
        begin
            send_message(4, sent);
        end
    endtask

    task automatic test_drain_pause();
        int sent;
        int m;
        send_idle_pct = 0;
        stall_pct     = 20;
        for (m = 0; m < 3; m++)
        begin
            send_message($urandom_range(1, 6), sent);
            in_valid <= 1'b0;
            wait (digest_queue.size() == 0);
        end
    endtask

    // Receiver: random stall, or a counted hold-off when one is requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_queue.size() == 0)
            begin
                $error("unexpected digest transaction: word %h index %0d", digest_word,
                       word_index);
                err_count++;
            end
            else
            begin
                head_word = digest_queue.pop_front();
                if (digest_word !== head_word.word)
                begin
                    $error("digest_word: expected %h, actual %h", head_word.word, digest_word);
                    err_count++;
                end
                if (word_index !== head_word.index)
                begin
                    $error("word_index: expected %0d, actual %0d", head_word.index, word_index);
                    err_count++;
                end
                if (last_word !== head_word.closing)
                begin
                    $error("last_word: expected %b, actual %b", head_word.closing, last_word);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #(8_000_000);
        $display("FAIL sha1_hash_unit");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = 8'h00;
        byte_valid = 1'b0;
        last       = 1'b0;
        clear_hash_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_block_boundaries();
        test_random_traffic(0, 0, 16);
        test_random_traffic(49, 0, 16);
        test_random_traffic(0, 49, 16);
        test_random_traffic(20, 20, 16);
        test_output_hold();
        test_drain_pause();

        in_valid <= 1'b0;
        wait (digest_queue.size() == 0);
        repeat (250) @(posedge clk);
        if (err_count == 0)
        begin
            $display("PASS sha1_hash_unit");
        end
        else
        begin
            $display("FAIL sha1_hash_unit");
        end
        $finish;
    end

endmodule

>>> sha1_hash_unit.f
src/sha1_pkg.sv
src/sha1_datapath.sv
src/sha1_ctrl.sv
src/sha1_hash_unit.sv
sim/testbench.sv
